### hdl/ir_distance_median_converter_unit_defines.svh
// Shared assertion macros, clocked on i_clk and qualified by i_rst_n.
`ifndef IR_DISTANCE_MEDIAN_CONVERTER_UNIT_DEFINES_SVH
`define IR_DISTANCE_MEDIAN_CONVERTER_UNIT_DEFINES_SVH

// Check in the same cycle, outside reset.
`define IDMC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check in the next cycle, outside reset.
`define IDMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Check the cycle after a reset cycle.
`define IDMC_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("reset assertion failed");

`endif

### hdl/idmc_pkg.sv
`default_nettype none

package idmc_pkg;

    localparam int WIN_SIZE    = 16;
    localparam int WIN_AW      = $clog2(WIN_SIZE);
    localparam int MED_IDX     = WIN_SIZE / 2;

    localparam int SAMPLE_W    = 10;
    localparam int MODEL_W     = 2;
    localparam int DIST_W      = 8;

    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = MODEL_W;
    localparam int OUT_TDATA_W = ((DIST_W + SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DIST_W - SAMPLE_W;

    localparam int ROM_AW      = MODEL_W + SAMPLE_W;
    localparam int ROM_DEPTH   = 1 << ROM_AW;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [MODEL_W-1:0]  t_model;
    typedef logic [DIST_W-1:0]   t_dist;

    typedef struct packed {
        logic    en;
        t_model  model;
        t_sample median;
    } t_rom_req;

endpackage

`default_nettype wire

### hdl/ir_distance_median_converter_unit.sv
// Infrared ranger median filter and distance converter.
// Input stream s_axis: tdata carries one 10-bit converter sample, tuser the
// sensor model (0 short range, 1 mid range, 2 long range, 3 unknown).
// Output stream m_axis: one beat per 16 input beats, carrying the distance
// in centimeters and the window median.
// Each sample is inserted into a sorted 16-entry window RAM by a sequencer
// that does one compare-and-shift step per cycle on a single comparator, a
// RAM write port and a RAM read port: the first beat of a window is stored
// in its accept cycle and leaves s_axis_tready high; any later beat holds
// s_axis_tready low while each stored entry larger than it moves up one
// place and the beat is written into the gap. After the beat that
// completes a window, the sequencer steps through median read, conversion
// ROM read and output load before m_axis_tvalid rises.
// The output register holds its beat while m_axis_tready is low; the next
// window is still collected, and only a second finished result waits in the
// sequencer until the held beat is taken.
// Synchronous active-low reset empties the window and drops any pending
// output; the window RAM itself is not cleared.
`default_nettype none

module ir_distance_median_converter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [9:0] adc_sample
    input  logic [idmc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] sensor_model
    input  logic [idmc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] distance_cm, [17:8] median_raw
    output logic [idmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import idmc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MROM = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [WIN_AW-1:0] r_fill,  n_fill;
    logic [WIN_AW-1:0] r_j,     n_j;
    t_sample           r_val,   n_val;
    t_model            r_model, n_model;
    t_sample           r_med,   n_med;
    logic              r_out_valid, n_out_valid;
    t_dist             r_out_dist;
    t_sample           r_out_med;

    t_sample           r_win [WIN_SIZE];
    t_sample           r_rd_data;

    logic              wr_en;
    logic [WIN_AW-1:0] wr_addr;
    t_sample           wr_data;
    logic [WIN_AW-1:0] rd_addr;

    logic              in_acc;
    logic              ins_last;
    logic [2:0]        fin_state;
    logic [WIN_AW-1:0] fin_fill;
    logic              out_load;

    t_rom_req          rom_req;
    t_dist             rom_dist;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign ins_last      = (r_fill == WIN_AW'(WIN_SIZE - 1));
    assign fin_state     = ins_last ? S_MRD : S_IDLE;
    assign fin_fill      = ins_last ? '0 : r_fill + WIN_AW'(1);
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_j            = r_j;
        n_val          = r_val;
        n_model        = r_model;
        n_med          = r_med;
        n_out_valid    = r_out_valid && !m_axis_tready;
        wr_en          = 1'b0;
        wr_addr        = r_j;
        wr_data        = r_val;
        rd_addr        = r_j - WIN_AW'(1);
        rom_req.en     = 1'b0;
        rom_req.model  = r_model;
        rom_req.median = r_rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val   = s_axis_tdata[SAMPLE_W-1:0];
                    n_model = s_axis_tuser[MODEL_W-1:0];
                    n_j     = r_fill;
                    if (r_fill == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = s_axis_tdata[SAMPLE_W-1:0];
                        n_state = fin_state;
                        n_fill  = fin_fill;
                    end else begin
                        rd_addr = r_fill - WIN_AW'(1);
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                if (r_rd_data > r_val) begin
                    wr_data = r_rd_data;
                    n_j     = r_j - WIN_AW'(1);
                    if (r_j == WIN_AW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        rd_addr = r_j - WIN_AW'(2);
                    end
                end else begin
                    wr_data = r_val;
                    n_state = fin_state;
                    n_fill  = fin_fill;
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_val;
                n_state = fin_state;
                n_fill  = fin_fill;
            end
            S_MRD: begin
                rd_addr = WIN_AW'(MED_IDX);
                n_state = S_MROM;
            end
            S_MROM: begin
                rom_req.en = 1'b1;
                n_med      = r_rd_data;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_val   <= n_val;
        r_model <= n_model;
        r_med   <= n_med;
        if (out_load) begin
            r_out_dist <= rom_dist;
            r_out_med  <= r_med;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_win[wr_addr] <= wr_data;
        end
        r_rd_data <= r_win[rd_addr];
    end

    idmc_conv_rom u_conv_rom (
        .i_clk  (i_clk),
        .i_req  (rom_req),
        .o_dist (rom_dist)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_med, r_out_dist};

endmodule

`default_nettype wire

### hdl/idmc_conv_rom.sv
`default_nettype none

module idmc_conv_rom (
    input  logic              i_clk,
    input  idmc_pkg::t_rom_req i_req,
    output idmc_pkg::t_dist    o_dist
);
    import idmc_pkg::*;

    localparam int LOG_FRAC     = 28;
    localparam int MV_SCALE     = 5000;
    localparam int ADC_FULL     = 1023;
    localparam int MV_REF       = 1000;
    localparam int MED_FAR_MAX  = 150;
    localparam int MED_OPEN_MAX = 1000;
    localparam int SAMPLE_DEPTH = 1 << SAMPLE_W;
    localparam int MODEL_DEPTH  = 1 << MODEL_W;

    typedef logic [ROM_DEPTH-1:0][DIST_W-1:0] t_rom;

    function automatic longint log2_fx(input logic [31:0] n);
        logic [63:0] m;
        logic [63:0] r;
        int          p;
        if (n == 32'd0) begin
            return 64'sd0;
        end
        p = 0;
        for (int b = 0; b < 32; b++) begin
            if (n[b]) begin
                p = b;
            end
        end
        m = ({32'd0, n} << LOG_FRAC) >> p;
        r = 64'(p) << LOG_FRAC;
        for (int i = LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> LOG_FRAC;
            if (m >= (64'd2 << LOG_FRAC)) begin
                m    = m >> 1;
                r[i] = 1'b1;
            end
        end
        return longint'(r);
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        longint      lt [256];
        longint      l_ref;
        longint      rhs;
        longint      k;
        int          cn;
        int          cd;
        int          mv;
        logic [7:0]  d;
        logic [7:0]  t;
        logic [7:0]  far;
        l_ref = log2_fx(32'(MV_REF));
        lt[0] = 64'sd0;
        for (int v = 1; v < 256; v++) begin
            lt[v] = log2_fx(32'(v));
        end
        for (int md = 0; md < MODEL_DEPTH; md++) begin
            cn  = 60374;
            cd  = 1000;
            k   = 1160;
            far = 8'd150;
            if (md == 0) begin
                cn  = 1208;
                cd  = 100;
                k   = 1058;
                far = 8'd30;
            end else if (md == 1) begin
                cn  = 29988;
                cd  = 1000;
                k   = 1173;
                far = 8'd80;
            end
            for (int med = 0; med < SAMPLE_DEPTH; med++) begin
                d = 8'd0;
                if (md > 2 || med > MED_OPEN_MAX) begin
                    d = 8'd0;
                end else if (med > MED_FAR_MAX && med < MED_OPEN_MAX) begin
                    mv  = med * MV_SCALE / ADC_FULL;
                    rhs = 1000 * (log2_fx(32'(cn)) - log2_fx(32'(cd)))
                        - k * (log2_fx(32'(mv)) - l_ref);
                    for (int b = 7; b >= 0; b--) begin
                        t    = d;
                        t[b] = 1'b1;
                        if (1000 * lt[t] <= rhs) begin
                            d = t;
                        end
                    end
                end else begin
                    d = far;
                end
                rom[md * SAMPLE_DEPTH + med] = DIST_W'(d);
            end
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    t_dist r_dist;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_dist <= ROM[{i_req.model, i_req.median}];
        end
    end

    assign o_dist = r_dist;

endmodule

`default_nettype wire

### hdl/idmc_checker.sv
`default_nettype none

`include "ir_distance_median_converter_unit_defines.svh"

module idmc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [idmc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [idmc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [idmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import idmc_pkg::*;

    localparam t_dist DIST_MAX = DIST_W'(150);

    `IDMC_ASSERT_RST(a_rst_drops_out, !m_axis_tvalid)
    `IDMC_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `IDMC_ASSERT_IMPL(a_dist_range, m_axis_tvalid, m_axis_tdata[DIST_W-1:0] <= DIST_MAX)
    `IDMC_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:DIST_W+SAMPLE_W] == '0)

endmodule

bind ir_distance_median_converter_unit idmc_checker u_idmc_checker (.*);

`default_nettype wire
